FILE: src/skct_pkg.sv
// ----------------------------------------------------------------------------
// skct_pkg
// Shared sizes, codes and types of the sorted key count table.
// ----------------------------------------------------------------------------
`default_nettype none

package skct_pkg;

    localparam int DEPTH      = 64;
    localparam int KEY_BITS   = 32;
    localparam int COUNT_BITS = 16;

    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int OCC_BITS   = $clog2(DEPTH + 1);
    localparam int ENTRY_BITS = KEY_BITS + COUNT_BITS;

    // port field widths
    localparam int FUNC_W   = 2;
    localparam int KEYF_W   = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int CNTF_W   = 16;
    localparam int OCCF_W   = 7;

    localparam int IN_BITS  = FUNC_W + KEYF_W + POS_W;
    localparam int OUT_USED = STATUS_W + 1 + KEYF_W + CNTF_W + OCCF_W;
    localparam int OUT_BITS = ((OUT_USED + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_FIND   = 2'd2,
        FN_READ   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_MISSING = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_BADPOS  = 3'd4
    } status_t;

    typedef struct packed {
        status_t               status;
        logic                  found;
        logic [KEYF_W-1:0]     entry_key;
        logic [CNTF_W-1:0]     entry_count;
        logic [OCCF_W-1:0]     occupancy;
    } res_t;

endpackage

`default_nettype wire

FILE: src/skct_ram.sv
// ----------------------------------------------------------------------------
// skct_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skct_ram #(
    parameter int WIDTH     = 48,
    parameter int WORDS     = 64,
    parameter int ADDR_BITS = $clog2(WORDS)
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [WORDS];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/skct_ctrl.sv
// ----------------------------------------------------------------------------
// skct_ctrl
// Sequencer: linear search with one shared comparator, entry-by-entry shifts
// through the table RAM, result formation.
// ----------------------------------------------------------------------------
`default_nettype none

module skct_ctrl (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // item in
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [skct_pkg::FUNC_W-1:0]         in_func,
    input  wire logic [skct_pkg::KEYF_W-1:0]         in_key,
    input  wire logic [skct_pkg::POS_W-1:0]          in_pos,
    // result out
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output skct_pkg::res_t                           res,
    // table RAM
    output logic                                     ram_we,
    output logic [skct_pkg::IDX_BITS-1:0]            ram_waddr,
    output logic [skct_pkg::ENTRY_BITS-1:0]          ram_wdata,
    output logic [skct_pkg::IDX_BITS-1:0]            ram_raddr,
    input  wire logic [skct_pkg::ENTRY_BITS-1:0]     ram_rdata
);

    localparam int OB = skct_pkg::OCC_BITS;
    localparam int IB = skct_pkg::IDX_BITS;
    localparam int KB = skct_pkg::KEY_BITS;
    localparam int CB = skct_pkg::COUNT_BITS;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN_RD  = 8'b0000_0010,
        S_SCAN_CMP = 8'b0000_0100,
        S_SHIFT_RD = 8'b0000_1000,
        S_SHIFT_WR = 8'b0001_0000,
        S_PUT      = 8'b0010_0000,
        S_READ_RD  = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    skct_pkg::func_t     func_reg, func_next;
    logic [KB-1:0]       key_reg, key_next;
    logic [IB-1:0]       pos_reg, pos_next;
    logic [OB-1:0]       used_reg, used_next;
    logic [OB-1:0]       idx_reg, idx_next;
    logic [OB-1:0]       j_reg, j_next;
    skct_pkg::res_t      res_reg, res_next;

    logic [KB-1:0]       rd_key;
    logic [CB-1:0]       rd_cnt;
    logic [CB-1:0]       cnt_inc;
    logic [OB-1:0]       in_pos_ext;
    logic [OB-1:0]       j_dn, j_up, j_up2;

    assign rd_key     = ram_rdata[skct_pkg::ENTRY_BITS-1:CB];
    assign rd_cnt     = ram_rdata[CB-1:0];
    assign cnt_inc    = (rd_cnt == {CB{1'b1}}) ? rd_cnt : rd_cnt + CB'(1);
    assign in_pos_ext = OB'(in_pos);
    assign j_dn       = j_reg - OB'(1);
    assign j_up       = j_reg + OB'(1);
    assign j_up2      = j_reg + OB'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        key_reg  <= key_next;
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
        j_reg    <= j_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        used_next  = used_reg;
        idx_next   = idx_reg;
        j_next     = j_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_raddr  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = skct_pkg::func_t'(in_func);
                    key_next  = in_key[KB-1:0];
                    pos_next  = in_pos[IB-1:0];
                    idx_next  = '0;
                    res_next  = '0;
                    if (skct_pkg::func_t'(in_func) == skct_pkg::FN_INSERT)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else if (used_reg == '0)
                    begin
                        res_next.status = skct_pkg::ST_EMPTY;
                        state_next      = S_DONE;
                    end
                    else if (skct_pkg::func_t'(in_func) != skct_pkg::FN_READ)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else if (in_pos_ext >= used_reg)
                    begin
                        res_next.status = skct_pkg::ST_BADPOS;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ_RD;
                    end
                end
            end

            S_READ_RD:
            begin
                ram_raddr  = pos_reg;
                state_next = S_SCAN_CMP;
            end

            S_SCAN_RD:
            begin
                ram_raddr = idx_reg[IB-1:0];
                if (idx_reg >= used_reg)
                begin
                    // ran past the last key: miss, slot is the end of the list
                    if (func_reg != skct_pkg::FN_INSERT)
                    begin
                        res_next.status = skct_pkg::ST_MISSING;
                        state_next      = S_DONE;
                    end
                    else if (used_reg == OB'(skct_pkg::DEPTH))
                    begin
                        res_next.status = skct_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (func_reg == skct_pkg::FN_READ)
                begin
                    res_next.status      = skct_pkg::ST_OK;
                    res_next.found       = 1'b1;
                    res_next.entry_key   = skct_pkg::KEYF_W'(rd_key);
                    res_next.entry_count = skct_pkg::CNTF_W'(rd_cnt);
                    state_next           = S_DONE;
                end
                else if (rd_key < key_reg)
                begin
                    idx_next   = idx_reg + OB'(1);
                    state_next = S_SCAN_RD;
                end
                else if (rd_key == key_reg)
                begin
                    res_next.status    = skct_pkg::ST_OK;
                    res_next.found     = 1'b1;
                    res_next.entry_key = skct_pkg::KEYF_W'(key_reg);
                    case (func_reg)
                        skct_pkg::FN_INSERT:
                        begin
                            ram_we               = 1'b1;
                            ram_waddr            = idx_reg[IB-1:0];
                            ram_wdata            = {key_reg, cnt_inc};
                            res_next.entry_count = skct_pkg::CNTF_W'(cnt_inc);
                            state_next           = S_DONE;
                        end
                        skct_pkg::FN_REMOVE:
                        begin
                            res_next.entry_count = '0;
                            j_next               = idx_reg;
                            if (idx_reg + OB'(1) < used_reg)
                            begin
                                state_next = S_SHIFT_RD;
                            end
                            else
                            begin
                                used_next  = used_reg - OB'(1);
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            res_next.entry_count = skct_pkg::CNTF_W'(rd_cnt);
                            state_next           = S_DONE;
                        end
                    endcase
                end
                else
                begin
                    // first key above the search key: miss at this slot
                    if (func_reg != skct_pkg::FN_INSERT)
                    begin
                        res_next.status = skct_pkg::ST_MISSING;
                        state_next      = S_DONE;
                    end
                    else if (used_reg == OB'(skct_pkg::DEPTH))
                    begin
                        res_next.status = skct_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        j_next     = used_reg;
                        state_next = S_SHIFT_RD;
                    end
                end
            end

            S_SHIFT_RD:
            begin
                // insert moves entries up from the tail, remove moves them down
                if (func_reg == skct_pkg::FN_INSERT)
                begin
                    ram_raddr = j_dn[IB-1:0];
                end
                else
                begin
                    ram_raddr = j_up[IB-1:0];
                end
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg[IB-1:0];
                ram_wdata = ram_rdata;
                if (func_reg == skct_pkg::FN_INSERT)
                begin
                    j_next = j_dn;
                    if (j_dn == idx_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    j_next = j_up;
                    if (j_up2 >= used_reg)
                    begin
                        used_next  = used_reg - OB'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
            end

            S_PUT:
            begin
                ram_we               = 1'b1;
                ram_waddr            = idx_reg[IB-1:0];
                ram_wdata            = {key_reg, CB'(1)};
                used_next            = used_reg + OB'(1);
                res_next.status      = skct_pkg::ST_OK;
                res_next.found       = 1'b0;
                res_next.entry_key   = skct_pkg::KEYF_W'(key_reg);
                res_next.entry_count = skct_pkg::CNTF_W'(1);
                state_next           = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // occupancy always reflects the table after the operation
        res_next.occupancy = skct_pkg::OCCF_W'(used_next);
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

`default_nettype wire

FILE: src/sorted_key_count_table_core.sv
// ----------------------------------------------------------------------------
// sorted_key_count_table_core
// Sorted table of distinct keys with occurrence counts: insert, remove,
// find and read at index, one result per item.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | tdata fields (low bit first)
//  s_*     | in  | s_tvalid/s_tready  | func[1:0] key[33:2] position[39:34]
//  m_*     | out | m_tvalid/m_tready  | status[2:0] found[3] entry_key[35:4]
//          |     |                    | entry_count[51:36] occupancy[58:52]
//
// A linear search with one comparator reads and compares one entry at a time;
// insert and remove then move entries through the single-port-pair RAM one
// at a time, reading each and writing it back one slot over. Empty table and
// bad position are answered without a RAM access; read at index reads once.
// Reset clears the occupancy and control state, not the table contents; those need no clearing.
// A finished result sits in the output register; the next item is taken
// while it waits and stalls only when its own result is ready while that one still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_count_table_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [skct_pkg::IN_BITS-1:0]   s_tdata,  // func, key, position
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [skct_pkg::OUT_BITS-1:0]  m_tdata   // status, found, entry_key,
                                                          // entry_count, occupancy, pad
);

    localparam int KOFS = skct_pkg::FUNC_W;
    localparam int POFS = skct_pkg::FUNC_W + skct_pkg::KEYF_W;

    logic                                  res_valid;
    logic                                  res_ready;
    skct_pkg::res_t                        res;
    logic                                  ram_we;
    logic [skct_pkg::IDX_BITS-1:0]         ram_waddr;
    logic [skct_pkg::ENTRY_BITS-1:0]       ram_wdata;
    logic [skct_pkg::IDX_BITS-1:0]         ram_raddr;
    logic [skct_pkg::ENTRY_BITS-1:0]       ram_rdata;

    logic                                  out_valid_reg;
    skct_pkg::res_t                        out_data_reg;

    skct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tdata[skct_pkg::FUNC_W-1:0]),
        .in_key    (s_tdata[KOFS +: skct_pkg::KEYF_W]),
        .in_pos    (s_tdata[POFS +: skct_pkg::POS_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    skct_ram #(
        .WIDTH     (skct_pkg::ENTRY_BITS),
        .WORDS     (skct_pkg::DEPTH),
        .ADDR_BITS (skct_pkg::IDX_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        {(skct_pkg::OUT_BITS - skct_pkg::OUT_USED){1'b0}},
        out_data_reg.occupancy,
        out_data_reg.entry_count,
        out_data_reg.entry_key,
        out_data_reg.found,
        out_data_reg.status
    };

endmodule

`default_nettype wire
